>>> sv/mvpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvpm_pkg
// Shared types and constants for the stereo sample-playback mixer.
// ----------------------------------------------------------------------------
package mvpm_pkg;

    localparam int MAX_VOICES_DEF   = 16;
    localparam int STORE_FRAMES_DEF = 65536;
    localparam int GAIN_W           = 12;
    localparam int SAMP_W           = 16;
    localparam int LEN_W            = 17;
    localparam int ACC_W            = 40;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_MIX   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] sample_address;
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
        logic [11:0] voice_volume;
        logic        loop_enable;
        logic [16:0] sound_length;
        logic        buffer_end;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic [4:0]  active_voices;
        logic        clipped;
        logic        buffer_end_out;
    } out_item_t;

    // Multiplier control between sequencer and serial multiplier
    typedef struct packed {
        logic go;
        logic busy;
    } mul_ctl_t;

endpackage

>>> sv/mvpm_sermul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvpm_sermul
// Bit-serial signed x unsigned multiplier, one gain bit per cycle.
// ----------------------------------------------------------------------------
module mvpm_sermul (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               go,
    input  wire logic signed [mvpm_pkg::SAMP_W-1:0] samp_l,
    input  wire logic signed [mvpm_pkg::SAMP_W-1:0] samp_r,
    input  wire logic [mvpm_pkg::GAIN_W-1:0]        gain,
    output logic                                    busy,
    output logic signed [mvpm_pkg::SAMP_W+mvpm_pkg::GAIN_W:0] prod_l,
    output logic signed [mvpm_pkg::SAMP_W+mvpm_pkg::GAIN_W:0] prod_r
);
    localparam int PW = mvpm_pkg::SAMP_W + mvpm_pkg::GAIN_W + 1;

    logic [3:0] cnt_reg, cnt_next;
    logic [mvpm_pkg::GAIN_W-1:0] g_reg, g_next;
    logic signed [PW-1:0] ml_reg, ml_next, mr_reg, mr_next;
    logic signed [PW-1:0] pl_reg, pl_next, pr_reg, pr_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        g_next = g_reg;
        ml_next = ml_reg;
        mr_next = mr_reg;
        pl_next = pl_reg;
        pr_next = pr_reg;
        if (go)
        begin
            cnt_next = 4'(mvpm_pkg::GAIN_W);
            g_next = gain;
            ml_next = PW'(samp_l);
            mr_next = PW'(samp_r);
            pl_next = '0;
            pr_next = '0;
        end
        else if (cnt_reg != 4'd0)
        begin
            if (g_reg[0])
            begin
                pl_next = pl_reg + ml_reg;
                pr_next = pr_reg + mr_reg;
            end
            g_next = g_reg >> 1;
            ml_next = ml_reg <<< 1;
            mr_next = mr_reg <<< 1;
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        g_reg <= g_next;
        ml_reg <= ml_next;
        mr_reg <= mr_next;
        pl_reg <= pl_next;
        pr_reg <= pr_next;
    end

    assign busy = (cnt_reg != 4'd0);
    assign prod_l = pl_reg;
    assign prod_r = pr_reg;
endmodule
`default_nettype wire

>>> sv/mvpm_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvpm_store
// Stereo sample store, one write and one registered read port.
// ----------------------------------------------------------------------------
module mvpm_store #(
    parameter int STORE_FRAMES = mvpm_pkg::STORE_FRAMES_DEF,
    parameter int AW = $clog2(STORE_FRAMES)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [31:0]        rdata
);
    logic [31:0] mem [STORE_FRAMES];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> sv/multi_voice_pcm_mixer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_voice_pcm_mixer_top
// Stereo sample-playback mixer with serial multiply-accumulate.
// ----------------------------------------------------------------------------
// A load or start beat keeps busy high for one cycle, so the block takes no
// new beat of that kind until it is through with the last. A mix beat walks
// the voice slots in the scan state. With sound on, each active voice also
// takes a store read, a multiplier start, GAIN_W bit-serial steps, a done
// check and an accumulate. With sound muted an active voice only steps its
// position in its scan cycle. The serial multiplier therefore sets the cost
// of a mix. The result strobes for one cycle and cannot be held off; busy is
// already low in that cycle, so the next beat can be accepted at the edge that
// ends it.
// ----------------------------------------------------------------------------
module multi_voice_pcm_mixer_top #(
    parameter int MAX_VOICES   = mvpm_pkg::MAX_VOICES_DEF,
    parameter int STORE_FRAMES = mvpm_pkg::STORE_FRAMES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire mvpm_pkg::in_item_t in_item,
    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata,
    output logic                    out_valid,
    output mvpm_pkg::out_item_t     out_item
);
    localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int AW = $clog2(STORE_FRAMES);
    localparam int PW = mvpm_pkg::SAMP_W + mvpm_pkg::GAIN_W + 1;
    localparam int AC = mvpm_pkg::ACC_W;

    mvpm_pkg::state_t state_reg, state_next;
    mvpm_pkg::in_item_t item_reg;
    logic en_reg;
    logic [VW-1:0] v_reg, v_next;
    logic [MAX_VOICES-1:0] act_reg, lp_reg;
    logic [mvpm_pkg::GAIN_W-1:0] gain_reg [MAX_VOICES];
    logic [15:0] base_reg [MAX_VOICES];
    logic [mvpm_pkg::LEN_W-1:0] len_reg [MAX_VOICES];
    logic [15:0] pos_reg [MAX_VOICES];
    logic signed [AC-1:0] accl_reg, accr_reg;
    logic [6:0] cnt_reg;
    logic last_v;

    // store
    logic st_we;
    logic [15:0] st_sum;
    logic [31:0] st_rdata;

    assign st_we = (state_reg == mvpm_pkg::ST_IDLE) && start
                   && (in_item.action == mvpm_pkg::ACT_LOAD);
    assign st_sum = base_reg[v_reg] + pos_reg[v_reg];

    mvpm_store #(.STORE_FRAMES(STORE_FRAMES), .AW(AW)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (AW'(in_item.sample_address)),
        .wdata ({in_item.right_in, in_item.left_in}),
        .raddr (AW'(st_sum)),
        .rdata (st_rdata)
    );

    mvpm_pkg::mul_ctl_t mul;
    logic mul_go_reg;
    logic mul_busy;
    logic signed [PW-1:0] prod_l, prod_r;

    assign mul = '{go: mul_go_reg, busy: mul_busy};

    mvpm_sermul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (mul.go),
        .samp_l (st_rdata[15:0]),
        .samp_r (st_rdata[31:16]),
        .gain   (gain_reg[v_reg]),
        .busy   (mul_busy),
        .prod_l (prod_l),
        .prod_r (prod_r)
    );

    assign last_v = (32'(v_reg) == MAX_VOICES - 1);
    assign busy = (state_reg != mvpm_pkg::ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mvpm_pkg::ST_IDLE:
                if (start)
                    state_next = (in_item.action == mvpm_pkg::ACT_MIX)
                                 ? mvpm_pkg::ST_SCAN : mvpm_pkg::ST_DONE;
            mvpm_pkg::ST_SCAN:
                if (act_reg[v_reg] && en_reg)
                    state_next = mvpm_pkg::ST_READ;
                else if (last_v)
                    state_next = mvpm_pkg::ST_DONE;
            mvpm_pkg::ST_READ:
                state_next = mvpm_pkg::ST_MUL;
            mvpm_pkg::ST_MUL:
                if (!mul.busy && !mul.go)
                    state_next = mvpm_pkg::ST_ACC;
            mvpm_pkg::ST_ACC:
                state_next = last_v ? mvpm_pkg::ST_DONE : mvpm_pkg::ST_SCAN;
            mvpm_pkg::ST_DONE:
                state_next = mvpm_pkg::ST_IDLE;
            default:
                state_next = mvpm_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        v_next = v_reg;
        unique case (state_reg)
            mvpm_pkg::ST_IDLE: v_next = '0;
            mvpm_pkg::ST_SCAN:
                if (!(act_reg[v_reg] && en_reg) && !last_v)
                    v_next = v_reg + VW'(1);
            mvpm_pkg::ST_ACC:
                if (!last_v)
                    v_next = v_reg + VW'(1);
            default: v_next = v_reg;
        endcase
    end

    // voice step: position advance and end handling for the current slot
    logic step_now;
    logic [16:0] pos_inc;
    assign step_now = act_reg[v_reg] &&
        (((state_reg == mvpm_pkg::ST_SCAN) && !en_reg) ||
         (state_reg == mvpm_pkg::ST_ACC));
    assign pos_inc = {1'b0, pos_reg[v_reg]} + 17'd1;

    // first free slot for start
    logic [VW-1:0] free_idx;
    logic free_ok;
    always_comb
    begin
        free_idx = '0;
        free_ok = 1'b0;
        for (int i = MAX_VOICES - 1; i >= 0; i--)
        begin
            if (!act_reg[i])
            begin
                free_idx = VW'(i);
                free_ok = 1'b1;
            end
        end
    end

    logic [16:0] len_in;
    always_comb
    begin
        len_in = in_item.sound_length;
        if (len_in == 17'd0)
            len_in = 17'd1;
        else if (len_in > 17'd65536)
            len_in = 17'd65536;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mvpm_pkg::ST_IDLE;
            en_reg <= 1'b1;
            v_reg <= '0;
            act_reg <= '0;
            lp_reg <= '0;
            mul_go_reg <= 1'b0;
            cnt_reg <= '0;
            out_valid <= 1'b0;
            for (int i = 0; i < MAX_VOICES; i++)
            begin
                gain_reg[i] <= '0;
                base_reg[i] <= '0;
                len_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            v_reg <= v_next;
            mul_go_reg <= (state_reg == mvpm_pkg::ST_READ);
            out_valid <= (state_reg == mvpm_pkg::ST_DONE)
                         && (item_reg.action == mvpm_pkg::ACT_MIX);
            if (cfg_we)
                en_reg <= cfg_wdata;
            if ((state_reg == mvpm_pkg::ST_IDLE) && start)
            begin
                cnt_reg <= '0;
                if ((in_item.action == mvpm_pkg::ACT_START) && free_ok)
                begin
                    act_reg[free_idx] <= 1'b1;
                    lp_reg[free_idx] <= in_item.loop_enable;
                    gain_reg[free_idx] <= in_item.voice_volume;
                    base_reg[free_idx] <= in_item.sample_address;
                    len_reg[free_idx] <= len_in;
                    pos_reg[free_idx] <= '0;
                end
            end
            if (step_now)
            begin
                if (pos_inc >= len_reg[v_reg])
                begin
                    pos_reg[v_reg] <= '0;
                    if (!lp_reg[v_reg])
                        act_reg[v_reg] <= 1'b0;
                    else
                        cnt_reg <= cnt_reg + 7'd1;
                end
                else
                begin
                    pos_reg[v_reg] <= pos_inc[15:0];
                    cnt_reg <= cnt_reg + 7'd1;
                end
            end
        end
    end

    // payload
    logic signed [AC-1:0] ql, qr;
    logic signed [16:0] sl, sr;
    logic cl_l, cl_r;
    always_comb
    begin
        ql = accl_reg / 256;
        qr = accr_reg / 256;
        cl_l = (ql > 40'sd32767) || (ql < -40'sd32768);
        cl_r = (qr > 40'sd32767) || (qr < -40'sd32768);
        sl = (ql > 40'sd32767) ? 17'sd32767 : (ql < -40'sd32768) ? -17'sd32768 : ql[16:0];
        sr = (qr > 40'sd32767) ? 17'sd32767 : (qr < -40'sd32768) ? -17'sd32768 : qr[16:0];
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == mvpm_pkg::ST_IDLE) && start)
        begin
            item_reg <= in_item;
            accl_reg <= '0;
            accr_reg <= '0;
        end
        if (state_reg == mvpm_pkg::ST_ACC)
        begin
            accl_reg <= accl_reg + AC'(prod_l);
            accr_reg <= accr_reg + AC'(prod_r);
        end
        if (state_reg == mvpm_pkg::ST_DONE)
        begin
            out_item.left_sample <= en_reg ? sl[15:0] : '0;
            out_item.right_sample <= en_reg ? sr[15:0] : '0;
            out_item.clipped <= en_reg && (cl_l || cl_r);
            out_item.active_voices <= (cnt_reg > 7'd31) ? 5'd31 : cnt_reg[4:0];
            out_item.buffer_end_out <= item_reg.buffer_end;
        end
    end

`ifndef SYNTHESIS
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(busy)) else $error("result without work");
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |=> !out_valid) else $error("result held two cycles");
    a_mul_go: assert property (@(posedge clk) disable iff (!rst_n)
        mul.go |-> (state_reg == mvpm_pkg::ST_MUL)) else $error("mul start out of place");
`endif
endmodule
`default_nettype wire
